// File: hdl/cst_pkg.sv
// Shared types and constants for the client session table with aging.
// No dependencies; cst_unit and the top level import this package.
`timescale 1ns / 1ps
`default_nettype none

package cst_pkg;

    // Table geometry (output field widths fix these)
    localparam int SLOTS  = 16;
    localparam int IDX_W  = 4;
    localparam int SPAN_W = 5;

    // Entry layout in the table memory: {ip, port, seen_time}
    localparam int IP_W    = 32;
    localparam int PORT_W  = 16;
    localparam int TIME_W  = 32;
    localparam int ENTRY_W = IP_W + PORT_W + TIME_W;

    localparam logic [TIME_W-1:0] IDLE_TIMEOUT_RST = 32'd300;

    // Request function codes
    localparam logic FUNC_SEEN  = 1'b0;
    localparam logic FUNC_SWEEP = 1'b1;

    // Response status codes
    typedef enum logic [1:0] {
        STAT_REFRESH = 2'd0,
        STAT_ADDED   = 2'd1,
        STAT_FULL    = 2'd2,
        STAT_SWEEP   = 2'd3
    } stat_t;

    // Shared compare unit operations
    typedef enum logic {
        UOP_MATCH = 1'b0,
        UOP_STALE = 1'b1
    } uop_t;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_ADD,
        ST_RESULT
    } state_t;

endpackage

`default_nettype wire

// File: hdl/cst_if.sv
// Valid/ready channel interfaces for session table requests and responses.
// Depends on nothing; field widths follow the request and response formats.
`timescale 1ns / 1ps
`default_nettype none

interface cst_req_if;
    logic        valid;
    logic        ready;
    logic        func;
    logic [31:0] peer_ip;
    logic [15:0] peer_port;
    logic [31:0] now_seconds;

    modport source (output valid, func, peer_ip, peer_port, now_seconds, input ready);
    modport sink   (input valid, func, peer_ip, peer_port, now_seconds, output ready);
endinterface

interface cst_rsp_if;
    logic       valid;
    logic       ready;
    logic [1:0] status;
    logic [3:0] slot;
    logic [4:0] active_span;
    logic [4:0] evicted_count;

    modport source (output valid, status, slot, active_span, evicted_count, input ready);
    modport sink   (input valid, status, slot, active_span, evicted_count, output ready);
endinterface

`default_nettype wire

// File: hdl/cst_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module cst_ram #(
    parameter int WIDTH = 80,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// File: hdl/cst_unit.sv
// Shared compare unit: key match for seen requests, idle test for sweeps.
// Depends on cst_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cst_unit (
    input  wire cst_pkg::uop_t              op,
    input  wire logic [cst_pkg::IP_W-1:0]   key_ip,
    input  wire logic [cst_pkg::PORT_W-1:0] key_port,
    input  wire logic [cst_pkg::IP_W-1:0]   entry_ip,
    input  wire logic [cst_pkg::PORT_W-1:0] entry_port,
    input  wire logic [cst_pkg::TIME_W-1:0] now,
    input  wire logic [cst_pkg::TIME_W-1:0] seen_time,
    input  wire logic [cst_pkg::TIME_W-1:0] timeout,
    output logic                            hit
);
    import cst_pkg::*;

    logic [TIME_W-1:0] idle_time;

    // Wrapping idle time
    assign idle_time = now - seen_time;

    // Operation select
    always_comb
    begin
        case (op)
            UOP_MATCH: hit = (key_ip == entry_ip) && (key_port == entry_port);
            UOP_STALE: hit = idle_time > timeout;
            default:   hit = 1'b0;
        endcase
    end

endmodule

`default_nettype wire

// File: hdl/client_session_table_aging.sv
// Session table with aging: top level, sequencer and valid bits.
// Depends on cst_pkg, cst_if, cst_ram and cst_unit.
//
// A table of 16 peer sessions keyed by IPv4 address and UDP port. A seen
// request refreshes a matching entry or claims the lowest free slot (status
// full when none is left); a sweep request evicts entries idle longer than
// idle_timeout and shrinks the active span. Each request walks the active
// span one entry per cycle through the table memory and a single shared
// compare unit: a request is accepted, scans the span (a seen request stops
// at its match), takes an add step for a new entry, and then holds its
// response until rsp.ready. One request is in flight at a time.
// Valid bits reset to empty at once; there is no clearing pass. Write
// idle_timeout only while no request is in flight.
`timescale 1ns / 1ps
`default_nettype none

module client_session_table_aging (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_wr_en,
    input  wire logic [31:0] cfg_wr_data,
    cst_req_if.sink          req,
    cst_rsp_if.source        rsp
);
    import cst_pkg::*;

    // Sequencer and datapath registers
    state_t              state_reg, state_next;
    logic [TIME_W-1:0]   timeout_reg;
    logic [SLOTS-1:0]    valid_reg, valid_next;
    logic [SPAN_W-1:0]   span_reg, span_next;
    logic                func_reg, func_next;
    logic [IP_W-1:0]     ip_reg, ip_next;
    logic [PORT_W-1:0]   port_reg, port_next;
    logic [TIME_W-1:0]   now_reg, now_next;
    logic [IDX_W-1:0]    chk_idx_reg, chk_idx_next;
    logic                free_found_reg, free_found_next;
    logic [IDX_W-1:0]    free_idx_reg, free_idx_next;
    logic [SPAN_W-1:0]   keep_span_reg, keep_span_next;
    logic [SPAN_W-1:0]   evicted_reg, evicted_next;
    stat_t               status_reg, status_next;
    logic [IDX_W-1:0]    slot_reg, slot_next;

    // Control and memory signals
    logic                req_fire;
    logic                entry_v;
    logic                unit_hit;
    logic                scan_last;
    logic                add_full;
    logic [IDX_W-1:0]    add_slot;
    logic [SPAN_W-1:0]   chk_plus1;
    logic [SPAN_W-1:0]   keep_cur;
    logic                ram_we;
    logic [IDX_W-1:0]    ram_waddr;
    logic [IDX_W-1:0]    ram_raddr;
    logic [ENTRY_W-1:0]  ram_wdata;
    logic [ENTRY_W-1:0]  ram_rdata;
    uop_t                unit_op;

    // Entry memory: {ip, port, seen_time}
    cst_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (SLOTS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Shared compare unit
    assign unit_op = (func_reg == FUNC_SWEEP) ? UOP_STALE : UOP_MATCH;

    cst_unit u_unit (
        .op         (unit_op),
        .key_ip     (ip_reg),
        .key_port   (port_reg),
        .entry_ip   (ram_rdata[ENTRY_W-1 -: IP_W]),
        .entry_port (ram_rdata[TIME_W +: PORT_W]),
        .now        (now_reg),
        .seen_time  (ram_rdata[TIME_W-1:0]),
        .timeout    (timeout_reg),
        .hit        (unit_hit)
    );

    // Scan helpers
    assign req_fire  = req.valid && req.ready;
    assign entry_v   = valid_reg[chk_idx_reg];
    assign chk_plus1 = {1'b0, chk_idx_reg} + SPAN_W'(1);
    assign scan_last = (chk_plus1 == span_reg);
    assign keep_cur  = (entry_v && !unit_hit) ? chk_plus1 : keep_span_reg;
    assign add_full  = !free_found_reg && (span_reg == SPAN_W'(SLOTS));
    assign add_slot  = free_found_reg ? free_idx_reg : span_reg[IDX_W-1:0];

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (req_fire)
                begin
                    if (span_reg == '0)
                        state_next = (req.func == FUNC_SWEEP) ? ST_RESULT : ST_ADD;
                    else
                        state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (func_reg == FUNC_SEEN && entry_v && unit_hit)
                    state_next = ST_RESULT;
                else if (scan_last)
                    state_next = (func_reg == FUNC_SEEN) ? ST_ADD : ST_RESULT;
            end
            ST_ADD:
            begin
                state_next = ST_RESULT;
            end
            ST_RESULT:
            begin
                if (rsp.ready)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Outputs: handshakes and memory control
    always_comb
    begin
        req.ready = 1'b0;
        rsp.valid = 1'b0;
        ram_we    = 1'b0;
        ram_waddr = chk_idx_reg;
        ram_raddr = chk_idx_reg + IDX_W'(1);
        case (state_reg)
            ST_IDLE:
            begin
                req.ready = 1'b1;
                ram_raddr = '0;
            end
            ST_SCAN:
            begin
                ram_we = (func_reg == FUNC_SEEN) && entry_v && unit_hit;
            end
            ST_ADD:
            begin
                ram_we    = !add_full;
                ram_waddr = add_slot;
            end
            ST_RESULT:
            begin
                rsp.valid = 1'b1;
            end
            default:
            begin
                req.ready = 1'b0;
            end
        endcase
    end

    assign ram_wdata = {ip_reg, port_reg, now_reg};

    // Datapath next values
    always_comb
    begin
        valid_next      = valid_reg;
        span_next       = span_reg;
        func_next       = func_reg;
        ip_next         = ip_reg;
        port_next       = port_reg;
        now_next        = now_reg;
        chk_idx_next    = chk_idx_reg;
        free_found_next = free_found_reg;
        free_idx_next   = free_idx_reg;
        keep_span_next  = keep_span_reg;
        evicted_next    = evicted_reg;
        status_next     = status_reg;
        slot_next       = slot_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (req_fire)
                begin
                    func_next       = req.func;
                    ip_next         = req.peer_ip;
                    port_next       = req.peer_port;
                    now_next        = req.now_seconds;
                    chk_idx_next    = '0;
                    free_found_next = 1'b0;
                    free_idx_next   = '0;
                    keep_span_next  = '0;
                    evicted_next    = '0;
                    slot_next       = '0;
                    status_next     = (req.func == FUNC_SWEEP) ? STAT_SWEEP : STAT_FULL;
                end
            end
            ST_SCAN:
            begin
                chk_idx_next = chk_idx_reg + IDX_W'(1);
                if (func_reg == FUNC_SEEN)
                begin
                    if (entry_v && unit_hit)
                    begin
                        status_next = STAT_REFRESH;
                        slot_next   = chk_idx_reg;
                    end
                    else if (!entry_v && !free_found_reg)
                    begin
                        free_found_next = 1'b1;
                        free_idx_next   = chk_idx_reg;
                    end
                end
                else
                begin
                    // Evict stale entries, remember the highest survivor
                    if (entry_v && unit_hit)
                    begin
                        valid_next[chk_idx_reg] = 1'b0;
                        evicted_next            = evicted_reg + SPAN_W'(1);
                    end
                    keep_span_next = keep_cur;
                    if (scan_last)
                        span_next = keep_cur;
                end
            end
            ST_ADD:
            begin
                if (!add_full)
                begin
                    status_next          = STAT_ADDED;
                    slot_next            = add_slot;
                    valid_next[add_slot] = 1'b1;
                    if (!free_found_reg)
                        span_next = span_reg + SPAN_W'(1);
                end
            end
            default:
            begin
                slot_next = slot_reg;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            valid_reg   <= '0;
            span_reg    <= '0;
            timeout_reg <= IDLE_TIMEOUT_RST;
        end
        else
        begin
            state_reg <= state_next;
            valid_reg <= valid_next;
            span_reg  <= span_next;
            if (cfg_wr_en)
                timeout_reg <= cfg_wr_data;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        func_reg       <= func_next;
        ip_reg         <= ip_next;
        port_reg       <= port_next;
        now_reg        <= now_next;
        chk_idx_reg    <= chk_idx_next;
        free_found_reg <= free_found_next;
        free_idx_reg   <= free_idx_next;
        keep_span_reg  <= keep_span_next;
        evicted_reg    <= evicted_next;
        status_reg     <= status_next;
        slot_reg       <= slot_next;
    end

    // Response payload
    assign rsp.status        = status_reg;
    assign rsp.slot          = slot_reg;
    assign rsp.active_span   = span_reg;
    assign rsp.evicted_count = evicted_reg;

`ifndef SYNTHESIS
    // Span never exceeds the table size
    a_span_bound: assert property (@(posedge clk) disable iff (!rst_n)
        span_reg <= SPAN_W'(SLOTS))
        else $error("active span beyond table size");

    // Between requests, no valid entry lies at or above the span
    a_span_cover: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> ((valid_reg >> span_reg) == '0))
        else $error("valid entry outside active span");

    // A new entry is valid when its response is shown
    a_added_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.status == STAT_ADDED) |-> valid_reg[rsp.slot])
        else $error("added slot not marked valid");

    // Only sweeps report evictions
    a_evict_sweep: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.status != STAT_SWEEP) |-> (rsp.evicted_count == '0))
        else $error("eviction count on seen response");

    // Sweeps never write the entry memory
    a_sweep_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (func_reg == FUNC_SEEN))
        else $error("memory write during sweep");
`endif

endmodule

`default_nettype wire
